// ----- src/lkvc_pkg.sv -----
// Shared types and constants of the LRU key-value cache.
package lkvc_pkg;

	// Default number of cache entries
	localparam int ENTRIES_DEF = 16;

	// Field widths
	localparam int DATA_W = 32;
	localparam int CAP_W = 5;

	// Capacity register after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Action codes
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	// One accepted request
	typedef struct packed {
		logic              action;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} item_t;

	// One response
	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] read_value;
		logic              evicted;
	} result_t;

endpackage

// ----- src/lkvc_ifs.sv -----
// Valid/ready channel interfaces of the LRU key-value cache.
interface lkvc_req_if;
	logic                                valid;
	logic                                ready;
	logic                                action;
	logic signed [lkvc_pkg::DATA_W-1:0]  key;
	logic signed [lkvc_pkg::DATA_W-1:0]  value;

	modport source (output valid, output action, output key, output value, input ready);
	modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                found;
	logic signed [lkvc_pkg::DATA_W-1:0]  read_value;
	logic                                evicted;

	modport source (output valid, output found, output read_value, output evicted, input ready);
	modport sink   (input valid, input found, input read_value, input evicted, output ready);
endinterface

interface lkvc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lkvc_pkg::CAP_W-1:0]    data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/lkvc_ram.sv -----
// Simple dual-port RAM with registered read, used for keys, values and ranks.
module lkvc_ram #(
	parameter int DEPTH = lkvc_pkg::ENTRIES_DEF,
	parameter int WIDTH = lkvc_pkg::DATA_W,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word and register one read word per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/lkvc_seq.sv -----
// Sequencer that scans entries through one shared key comparator and sweeps rank updates.
module lkvc_seq #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  lkvc_pkg::item_t             item,
	output logic                        idle,
	input  logic [lkvc_pkg::CAP_W-1:0]  capacity,
	output logic                        res_valid,
	input  logic                        res_ready,
	output lkvc_pkg::result_t           result
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int CMPW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_UPD    = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]              state_q;
	logic [CW-1:0]           rd_cnt_q;
	logic                    cmp_vld_q;
	logic [AW-1:0]           cmp_idx_q;
	logic [ENTRIES-1:0]      valid_q;
	logic [CW-1:0]           occ_q;
	logic                    hit_q, lru_any_q, free_any_q;
	logic [AW-1:0]           hit_idx_q, lru_idx_q, free_idx_q;
	logic [AW-1:0]           hit_rank_q, lru_rank_q;
	logic [lkvc_pkg::DATA_W-1:0] hit_val_q;
	logic [AW-1:0]           s_q, r_q;
	lkvc_pkg::item_t         item_q;
	lkvc_pkg::result_t       res_q;

	logic [AW-1:0]           raddr;
	logic [lkvc_pkg::DATA_W-1:0] key_rd, val_rd;
	logic [AW-1:0]           rank_rd;
	logic                    issue, last, ent_valid, key_match;
	logic [CMPW-1:0]         cap_w, lim_w, occ_w;
	logic                    full;
	logic [AW-1:0]           dec_s, dec_r;
	logic                    dec_evict, dec_insert, dec_kv_we, dec_promote;
	logic                    kv_we;
	logic                    rank_we;
	logic [AW-1:0]           rank_wdata;

	// Key, value and rank stores
	lkvc_ram #(.DEPTH(ENTRIES), .WIDTH(lkvc_pkg::DATA_W)) u_key_ram (
		.clk(clk), .we(kv_we), .waddr(dec_s), .wdata(item_q.key),
		.raddr(raddr), .rdata(key_rd)
	);

	lkvc_ram #(.DEPTH(ENTRIES), .WIDTH(lkvc_pkg::DATA_W)) u_val_ram (
		.clk(clk), .we(kv_we), .waddr(dec_s), .wdata(item_q.value),
		.raddr(raddr), .rdata(val_rd)
	);

	lkvc_ram #(.DEPTH(ENTRIES), .WIDTH(AW)) u_rank_ram (
		.clk(clk), .we(rank_we), .waddr(cmp_idx_q), .wdata(rank_wdata),
		.raddr(raddr), .rdata(rank_rd)
	);

	// Walk addresses and compare the entry read in the previous cycle
	always_comb begin
		raddr = rd_cnt_q[AW-1:0];
		issue = ((state_q == S_SCAN) || (state_q == S_UPD)) && (rd_cnt_q < CW'(ENTRIES));
		last = cmp_vld_q && (cmp_idx_q == LAST);
		ent_valid = valid_q[cmp_idx_q];
		key_match = ent_valid && (key_rd == item_q.key);
	end

	// Clamp capacity to 1..ENTRIES and check for a full cache
	always_comb begin
		cap_w = CMPW'(capacity);
		occ_w = CMPW'(occ_q);
		if (cap_w == '0) begin
			lim_w = CMPW'(1);
		end else if (cap_w > CMPW'(ENTRIES)) begin
			lim_w = CMPW'(ENTRIES);
		end else begin
			lim_w = cap_w;
		end
		full = occ_w >= lim_w;
	end

	// Pick the slot to touch and the rank it leaves
	always_comb begin
		dec_s = hit_idx_q;
		dec_r = hit_rank_q;
		dec_evict = 1'b0;
		dec_insert = 1'b0;
		dec_kv_we = 1'b0;
		dec_promote = 1'b0;
		if (hit_q) begin
			dec_promote = 1'b1;
			dec_kv_we = (item_q.action == lkvc_pkg::ACT_PUT);
		end else if (item_q.action == lkvc_pkg::ACT_PUT) begin
			if (full && lru_any_q) begin
				dec_s = lru_idx_q;
				dec_r = lru_rank_q;
				dec_evict = 1'b1;
				dec_kv_we = 1'b1;
				dec_promote = 1'b1;
			end else if (free_any_q) begin
				dec_s = free_idx_q;
				dec_r = AW'(occ_q);
				dec_insert = 1'b1;
				dec_kv_we = 1'b1;
				dec_promote = 1'b1;
			end
		end
		kv_we = (state_q == S_DECIDE) && dec_kv_we;
	end

	// Bump the ranks lower than the promoted slot's old rank, zero the slot itself
	always_comb begin
		rank_we = (state_q == S_UPD) && cmp_vld_q &&
			((cmp_idx_q == s_q) || (ent_valid && (rank_rd < r_q)));
		rank_wdata = (cmp_idx_q == s_q) ? '0 : rank_rd + AW'(1);
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_cnt_q <= '0;
			cmp_vld_q <= 1'b0;
			valid_q <= '0;
			occ_q <= '0;
			hit_q <= 1'b0;
			lru_any_q <= 1'b0;
			free_any_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						rd_cnt_q <= '0;
						cmp_vld_q <= 1'b0;
						hit_q <= 1'b0;
						lru_any_q <= 1'b0;
						free_any_q <= 1'b0;
					end
				end
				S_SCAN: begin
					cmp_vld_q <= issue;
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (cmp_vld_q) begin
						if (key_match && !hit_q) begin
							hit_q <= 1'b1;
						end
						if (ent_valid && (!lru_any_q || (rank_rd > lru_rank_q))) begin
							lru_any_q <= 1'b1;
						end
						if (!ent_valid && !free_any_q) begin
							free_any_q <= 1'b1;
						end
					end
					if (last) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (dec_insert) begin
						valid_q[dec_s] <= 1'b1;
						occ_q <= occ_q + CW'(1);
					end
					rd_cnt_q <= '0;
					cmp_vld_q <= 1'b0;
					state_q <= dec_promote ? S_UPD : S_DONE;
				end
				S_UPD: begin
					cmp_vld_q <= issue;
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the request, scan findings and the response
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			item_q <= item;
		end
		cmp_idx_q <= raddr;
		if ((state_q == S_SCAN) && cmp_vld_q) begin
			if (key_match && !hit_q) begin
				hit_idx_q <= cmp_idx_q;
				hit_rank_q <= rank_rd;
				hit_val_q <= val_rd;
			end
			if (ent_valid && (!lru_any_q || (rank_rd > lru_rank_q))) begin
				lru_idx_q <= cmp_idx_q;
				lru_rank_q <= rank_rd;
			end
			if (!ent_valid && !free_any_q) begin
				free_idx_q <= cmp_idx_q;
			end
		end
		if (state_q == S_DECIDE) begin
			s_q <= dec_s;
			r_q <= dec_r;
			res_q.found <= hit_q;
			res_q.read_value <= (hit_q && (item_q.action == lkvc_pkg::ACT_GET)) ?
				hit_val_q : '1;
			res_q.evicted <= dec_evict;
		end
	end

	assign idle = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign result = res_q;

endmodule

// ----- src/lru_key_value_cache_unit.sv -----
// Top level of the fully associative LRU key-value cache.
//
// Requests arrive on req (action, key, value); a transfer happens when valid
// and ready are both high. Each request gives exactly one response on rsp
// (found, read_value, evicted). The capacity register is written through cfg,
// which is always ready; write it only while no request is in flight.
//
// One request at a time: req.ready is high only while the sequencer is idle.
// The sequencer reads one entry per cycle from the key, value and rank RAMs
// through a single key comparator, decides the slot, then, unless a get
// misses, sweeps the rank RAM once more as a read-modify-write pass to move
// the touched entry to most recent.
//
// The response sits in an output register, so the next request is taken
// while an earlier response still waits; a further response waits in the
// sequencer until rsp is taken. Reset clears all valid marks, occupancy,
// and sets capacity to 16; keys and values are not cleared.
module lru_key_value_cache_unit #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	lkvc_req_if.sink   req,
	lkvc_rsp_if.source rsp,
	lkvc_cfg_if.sink   cfg
);

	logic [lkvc_pkg::CAP_W-1:0] capacity_q;
	logic                       seq_idle;
	logic                       start;
	lkvc_pkg::item_t            item;
	logic                       res_valid, res_ready, res_take;
	lkvc_pkg::result_t          result;
	logic                       out_vld_q;
	lkvc_pkg::result_t          out_q;

	// Capacity register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			capacity_q <= cfg.data;
		end
	end

	// Accept a request while the sequencer is idle
	assign req.ready = seq_idle;
	assign start = req.valid && seq_idle;
	assign item = '{action: req.action, key: req.key, value: req.value};

	lkvc_seq #(.ENTRIES(ENTRIES)) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.idle(seq_idle),
		.capacity(capacity_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.result(result)
	);

	// Output register: load when empty or being drained
	assign res_ready = !out_vld_q || rsp.ready;
	assign res_take = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_take) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= result;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.found = out_q.found;
	assign rsp.read_value = out_q.read_value;
	assign rsp.evicted = out_q.evicted;

	// Block is busy in the cycle after a request transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while a previous one is in flight");

	// An eviction only happens on a put that missed
	a_evict_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.evicted && rsp.found))
		else $error("eviction reported on a hit");

	// A miss always reads back all ones
	a_miss_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.read_value == '1))
		else $error("miss returned a value other than all ones");

	// A new response is loaded only when the output register frees up
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !rsp.ready) |-> !res_take)
		else $error("pending response overwritten");

endmodule
